### rtl/core/deq_pkg.sv
// Shared types, constants and index helpers for the double-ended queue core.
// No dependencies; imported by deq_ring and double_ended_queue_core.
package deq_pkg;

	localparam int QUEUE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int WORD_W      = 32;

	// operation codes
	localparam logic [2:0] OP_QUERY      = 3'd0;
	localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd2;
	localparam logic [2:0] OP_POP_FRONT  = 3'd3;
	localparam logic [2:0] OP_POP_BACK   = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	// one write request into the ring store
	typedef struct packed {
		logic  en;
		idx_t  addr;
		word_t data;
	} ring_wr_t;

	// index step with wrap at the queue depth
	function automatic idx_t idx_inc(input idx_t i);
		return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + IDX_W'(1);
	endfunction

	function automatic idx_t idx_dec(input idx_t i);
		return (i == '0) ? IDX_W'(QUEUE_DEPTH - 1) : i - IDX_W'(1);
	endfunction

endpackage

### rtl/core/double_ended_queue_core.sv
// Double-ended queue core: push/pop at either end, one result per item.
// Accepted items pass the input register, then the result register.
// Throughput: one item per cycle while res_stall is low, set by the single
// state update and the two prefetch reads of the ring store (next-front and
// next-back words). Reset clears head, tail, count and valid flags; the ring
// store is not initialized and needs no clearing pass. Depends on deq_pkg, deq_ring.
module double_ended_queue_core
	import deq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [2:0]  operation,
	input  word_t       push_value,
	output logic        res_valid,
	input  logic        res_stall,
	output word_t       popped_value,
	output logic [1:0]  status,
	output cnt_t        entry_count,
	output logic        is_empty,
	output word_t       front_value,
	output word_t       back_value
);

	// input register
	logic       valid_s1;
	logic [2:0] op_s1;
	word_t      val_s1;

	// queue state and cached end words
	idx_t  head_q;
	idx_t  tail_q;
	cnt_t  count_q;
	word_t front_q;
	word_t back_q;

	// result register
	logic       valid_s2;
	word_t      popped_s2;
	logic [1:0] status_s2;
	cnt_t       count_s2;
	logic       empty_s2;
	word_t      front_s2;
	word_t      back_s2;

	logic     advance;
	logic     take_cmd;
	idx_t     head_n;
	idx_t     tail_n;
	cnt_t     count_n;
	word_t    front_n;
	word_t    back_n;
	word_t    popped_n;
	logic [1:0] status_n;
	ring_wr_t wr_raw;
	ring_wr_t wr;
	idx_t     head_sel;
	idx_t     tail_sel;
	word_t    next_front;
	word_t    next_back;
	logic     q_empty;
	logic     q_full;
	logic     q_multi;

	// handshake
	assign advance   = valid_s1 && (!valid_s2 || !res_stall);
	assign cmd_stall = valid_s1 && !advance;
	assign take_cmd  = cmd_valid && !cmd_stall;

	assign q_empty = (count_q == '0);
	assign q_full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign q_multi = (count_q > CNT_W'(1));

	// operation on the current state
	always_comb begin
		head_n   = head_q;
		tail_n   = tail_q;
		count_n  = count_q;
		front_n  = front_q;
		back_n   = back_q;
		popped_n = '0;
		status_n = ST_OK;
		wr_raw   = '0;
		unique case (op_s1)
			OP_PUSH_FRONT: begin
				if (q_full) begin
					status_n = ST_FULL;
				end else begin
					head_n      = idx_dec(head_q);
					wr_raw.en   = 1'b1;
					wr_raw.addr = head_n;
					wr_raw.data = val_s1;
					count_n     = count_q + CNT_W'(1);
					front_n     = val_s1;
					if (q_empty) begin
						back_n = val_s1;
					end
				end
			end
			OP_PUSH_BACK: begin
				if (q_full) begin
					status_n = ST_FULL;
				end else begin
					tail_n      = idx_inc(tail_q);
					wr_raw.en   = 1'b1;
					wr_raw.addr = tail_q;
					wr_raw.data = val_s1;
					count_n     = count_q + CNT_W'(1);
					back_n      = val_s1;
					if (q_empty) begin
						front_n = val_s1;
					end
				end
			end
			OP_POP_FRONT: begin
				if (q_empty) begin
					status_n = ST_EMPTY;
				end else begin
					popped_n = front_q;
					head_n   = idx_inc(head_q);
					count_n  = count_q - CNT_W'(1);
					if (q_multi) begin
						front_n = next_front;
					end
				end
			end
			OP_POP_BACK: begin
				if (q_empty) begin
					status_n = ST_EMPTY;
				end else begin
					popped_n = back_q;
					tail_n   = idx_dec(tail_q);
					count_n  = count_q - CNT_W'(1);
					if (q_multi) begin
						back_n = next_back;
					end
				end
			end
			default: begin
				// query and unused codes leave the state alone
			end
		endcase
	end

	assign wr       = '{en: wr_raw.en && advance, addr: wr_raw.addr, data: wr_raw.data};
	assign head_sel = advance ? head_n : head_q;
	assign tail_sel = advance ? tail_n : tail_q;

	// prefetch the words just inside each end for the next item
	deq_ring u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.rd_addr_a (idx_inc(head_sel)),
		.rd_addr_b (idx_dec(idx_dec(tail_sel))),
		.rd_data_a (next_front),
		.rd_data_b (next_back)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
		end else begin
			if (take_cmd) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			valid_s2 <= advance || (valid_s2 && res_stall);
			if (advance) begin
				head_q  <= head_n;
				tail_q  <= tail_n;
				count_q <= count_n;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take_cmd) begin
			op_s1  <= operation;
			val_s1 <= push_value;
		end
		if (advance) begin
			front_q   <= front_n;
			back_q    <= back_n;
			popped_s2 <= popped_n;
			status_s2 <= status_n;
			count_s2  <= count_n;
			empty_s2  <= (count_n == '0);
			front_s2  <= (count_n == '0) ? '0 : front_n;
			back_s2   <= (count_n == '0) ? '0 : back_n;
		end
	end

	assign res_valid    = valid_s2;
	assign popped_value = popped_s2;
	assign status       = status_s2;
	assign entry_count  = count_s2;
	assign is_empty     = empty_s2;
	assign front_value  = front_s2;
	assign back_value   = back_s2;

`ifndef ASSERT_OFF
	// count stays within the ring
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("stored count beyond queue depth");

	// an empty or full ring has its indices meeting
	a_idx_meet: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == CNT_W'(QUEUE_DEPTH)) |-> (head_q == tail_q))
		else $error("head and tail disagree with count");

	// no store write when the ring is full
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> !q_full)
		else $error("write into a full ring");

	// an empty-pop result reports an empty queue
	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status == ST_EMPTY) |-> (entry_count == '0 && is_empty))
		else $error("empty status with stored words");
`endif

endmodule

### rtl/core/deq_ring.sv
// Ring store of the queue: one write port, two registered read ports,
// with bypass of a write that lands on a read address in the same cycle.
// Depends on deq_pkg.
module deq_ring
	import deq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  ring_wr_t wr,
	input  idx_t     rd_addr_a,
	input  idx_t     rd_addr_b,
	output word_t    rd_data_a,
	output word_t    rd_data_b
);

	word_t mem [QUEUE_DEPTH];
	word_t rd_a_q;
	word_t rd_b_q;
	word_t wr_data_q;
	logic  hit_a_q;
	logic  hit_b_q;

	// storage write and read-before-write registered reads
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_a_q    <= mem[rd_addr_a];
		rd_b_q    <= mem[rd_addr_b];
		wr_data_q <= wr.data;
	end

	// note which read port saw a same-cycle write to its address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_a_q <= 1'b0;
			hit_b_q <= 1'b0;
		end else begin
			hit_a_q <= wr.en && (wr.addr == rd_addr_a);
			hit_b_q <= wr.en && (wr.addr == rd_addr_b);
		end
	end

	assign rd_data_a = hit_a_q ? wr_data_q : rd_a_q;
	assign rd_data_b = hit_b_q ? wr_data_q : rd_b_q;

endmodule
